// File: hdl/safs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safs_pkg : shared types and codes of the slot allocator
// Payload structs, operation and status codes, register map and defaults.
// ----------------------------------------------------------------------------
package safs_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_SLOTS_DEF    = 256;
  localparam int TARGET_WIDTH_DEF = 64;

  // Fixed field widths
  localparam int MODE_W = 2;
  localparam int SLOT_W = 8;
  localparam int WORD_W = 64;
  localparam int STAT_W = 2;

  // Configuration register
  localparam int            CAP_W             = 9;
  localparam logic [CAP_W-1:0] CAP_RESET      = 9'd256;
  localparam int            PADDR_W           = 3;
  localparam logic [PADDR_W-1:0] REG_SLOT_CAPACITY = 3'd0;

  // Request modes as seen on the port
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

  // Internal operation codes after classification
  typedef logic [1:0] op_t;
  localparam op_t OP_ALLOC   = 2'd0;
  localparam op_t OP_RELEASE = 2'd1;
  localparam op_t OP_LOOKUP  = 2'd2;
  localparam op_t OP_NOP     = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADREL = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISS   = 2'd3;

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot_index;
    logic [WORD_W-1:0] target_word;
  } req_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_given;
    logic [WORD_W-1:0] target_read;
  } rsp_item_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot_index;
    logic [WORD_W-1:0] target_word;
  } queue_item_t;

endpackage

// File: hdl/slot_allocator_free_stack_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_allocator_free_stack_core : slot allocator with LIFO free stack
// Allocate, release and lookup requests on a slot table with a bump pointer.
//
//   channel  signals                       direction  transaction
//   req      req_valid/req_ready/req       in         one request
//   rsp      rsp_valid/rsp_ready/rsp       out        one result per request
//   apb      psel/penable/pwrite/paddr/..  in/out     slot_capacity register
//
// A request passes two steps in the execution side: the registered table
// read (target store, ready marks, stack top), then the update and issue.
// A two-entry queue sits between intake and execution; the result register
// holds each result until it is taken, and execution only finishes into it
// when it is empty or being taken in the same cycle.
// No clearing pass after reset: high_water bounds which ready marks are trusted.
// A stalled result holds execution, which then backs up into the queue.
// ----------------------------------------------------------------------------
module slot_allocator_free_stack_core #(
  parameter int MAX_SLOTS    = safs_pkg::MAX_SLOTS_DEF,
  parameter int TARGET_WIDTH = safs_pkg::TARGET_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  safs_pkg::req_item_t           req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output safs_pkg::rsp_item_t           rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [safs_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [safs_pkg::CAP_W-1:0] slot_capacity;
  logic                       q_valid;
  logic                       q_pop;
  safs_pkg::queue_item_t      q_head;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr == safs_pkg::REG_SLOT_CAPACITY) ? 32'(slot_capacity) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_capacity <= safs_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == safs_pkg::REG_SLOT_CAPACITY)) begin
      slot_capacity <= pwdata[safs_pkg::CAP_W-1:0];
    end
  end

  safs_front #(.TARGET_WIDTH(TARGET_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_head    (q_head)
  );

  safs_back #(.MAX_SLOTS(MAX_SLOTS), .TARGET_WIDTH(TARGET_WIDTH)) u_back (
    .clk           (clk),
    .rst           (rst),
    .slot_capacity (slot_capacity),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_head        (q_head),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .rsp           (rsp)
  );

endmodule

// File: hdl/safs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safs_ram : generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module safs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/safs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safs_front : request intake
// Accepts request transactions, decodes the mode, trims the target word and
// holds the result in a two-entry queue for the execution side.
// ----------------------------------------------------------------------------
module safs_front #(
  parameter int TARGET_WIDTH = safs_pkg::TARGET_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  safs_pkg::req_item_t    req,
  output logic                   q_valid,
  input  logic                   q_pop,
  output safs_pkg::queue_item_t  q_head
);

  localparam logic [safs_pkg::WORD_W-1:0] WORD_MASK =
    {safs_pkg::WORD_W{1'b1}} >> (safs_pkg::WORD_W - TARGET_WIDTH);

  safs_pkg::queue_item_t         entry;
  safs_pkg::queue_item_t         q_mem [safs_pkg::QUEUE_DEPTH];
  logic [safs_pkg::QPTR_W-1:0]   wr_ptr;
  logic [safs_pkg::QPTR_W-1:0]   rd_ptr;
  logic [safs_pkg::QCNT_W-1:0]   count;
  logic                          push;
  logic                          pop;

  // Classify the incoming request
  always_comb begin
    entry.slot_index  = req.slot_index;
    entry.target_word = req.target_word & WORD_MASK;
    unique case (req.mode)
      safs_pkg::MODE_ALLOC:   entry.op = safs_pkg::OP_ALLOC;
      safs_pkg::MODE_RELEASE: entry.op = safs_pkg::OP_RELEASE;
      safs_pkg::MODE_LOOKUP:  entry.op = safs_pkg::OP_LOOKUP;
      safs_pkg::MODE_UNUSED:  entry.op = safs_pkg::OP_NOP;
    endcase
  end

  assign req_ready = (count != safs_pkg::QCNT_W'(safs_pkg::QUEUE_DEPTH));
  assign push      = req_valid && req_ready;
  assign pop       = q_pop && q_valid;
  assign q_valid   = (count != '0);
  assign q_head    = q_mem[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= entry;
    end
  end

  // Queue pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// File: hdl/safs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// safs_back : request execution
// Takes one queued request at a time, reads the tables, then updates the
// ready marks, free stack, bump pointer and target store and issues a result.
// ----------------------------------------------------------------------------
module safs_back #(
  parameter int MAX_SLOTS    = safs_pkg::MAX_SLOTS_DEF,
  parameter int TARGET_WIDTH = safs_pkg::TARGET_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [safs_pkg::CAP_W-1:0]   slot_capacity,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  safs_pkg::queue_item_t        q_head,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output safs_pkg::rsp_item_t          rsp
);

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W = (CNT_W > safs_pkg::CAP_W) ? CNT_W : safs_pkg::CAP_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0]               state;
  logic [1:0]               state_next;
  safs_pkg::queue_item_t    item;
  logic [CNT_W-1:0]         free_depth;
  logic [CNT_W-1:0]         free_depth_next;
  logic [CNT_W-1:0]         high_water;
  logic [CNT_W-1:0]         high_water_next;

  logic                     take;
  logic                     exec_done;
  logic                     live;
  logic [CMP_W-1:0]         cap_ext;
  logic [CMP_W-1:0]         cap_eff;
  logic [IDX_W-1:0]         slot_idx;
  logic [IDX_W-1:0]         pick;
  safs_pkg::rsp_item_t      result;

  logic                     tgt_we;
  logic                     rdy_we;
  logic                     rdy_wdata;
  logic                     stk_we;
  logic [IDX_W-1:0]         wr_idx;
  logic [TARGET_WIDTH-1:0]  tgt_rdata;
  logic                     rdy_rdata;
  logic [IDX_W-1:0]         stk_rdata;

  // Handshake with the queue and the result register
  assign exec_done = (state == ST_EXEC) && (!rsp_valid || rsp_ready);
  assign take      = q_valid && ((state == ST_IDLE) || exec_done);
  assign q_pop     = take;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (take) state_next = ST_RD;
      ST_RD:   state_next = ST_EXEC;
      ST_EXEC: if (exec_done) state_next = take ? ST_RD : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Tables: ready marks guarded by high_water, so no clearing is needed
  assign slot_idx = IDX_W'(item.slot_index);

  safs_ram #(.WIDTH(TARGET_WIDTH), .DEPTH(MAX_SLOTS)) u_target (
    .clk   (clk),
    .we    (tgt_we && exec_done),
    .waddr (wr_idx),
    .wdata (item.target_word[TARGET_WIDTH-1:0]),
    .raddr (slot_idx),
    .rdata (tgt_rdata)
  );

  safs_ram #(.WIDTH(1), .DEPTH(MAX_SLOTS)) u_ready (
    .clk   (clk),
    .we    (rdy_we && exec_done),
    .waddr (wr_idx),
    .wdata (rdy_wdata),
    .raddr (slot_idx),
    .rdata (rdy_rdata)
  );

  safs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_SLOTS)) u_stack (
    .clk   (clk),
    .we    (stk_we && exec_done),
    .waddr (IDX_W'(free_depth)),
    .wdata (slot_idx),
    .raddr (IDX_W'(free_depth - CNT_W'(1))),
    .rdata (stk_rdata)
  );

  // Effective capacity and liveness of the addressed slot
  assign cap_ext = CMP_W'(slot_capacity);
  assign cap_eff = (cap_ext < CMP_W'(MAX_SLOTS)) ? cap_ext : CMP_W'(MAX_SLOTS);
  assign live    = (CMP_W'(item.slot_index) < CMP_W'(high_water)) && rdy_rdata;

  // Execute the held request
  always_comb begin
    result.status      = safs_pkg::ST_OK;
    result.slot_given  = '0;
    result.target_read = '0;
    tgt_we             = 1'b0;
    rdy_we             = 1'b0;
    rdy_wdata          = 1'b0;
    stk_we             = 1'b0;
    wr_idx             = slot_idx;
    pick               = '0;
    free_depth_next    = free_depth;
    high_water_next    = high_water;
    unique case (item.op)
      safs_pkg::OP_ALLOC: begin
        priority if (free_depth != '0) begin
          pick            = stk_rdata;
          free_depth_next = free_depth - CNT_W'(1);
        end else if (CMP_W'(high_water) < cap_eff) begin
          pick            = IDX_W'(high_water);
          high_water_next = high_water + CNT_W'(1);
        end else begin
          result.status = safs_pkg::ST_FULL;
        end
        if (result.status == safs_pkg::ST_OK) begin
          tgt_we            = 1'b1;
          rdy_we            = 1'b1;
          rdy_wdata         = 1'b1;
          wr_idx            = pick;
          result.slot_given = safs_pkg::SLOT_W'(pick);
        end
      end
      safs_pkg::OP_RELEASE: begin
        if (live) begin
          rdy_we = 1'b1;
          if (free_depth < CNT_W'(MAX_SLOTS)) begin
            stk_we          = 1'b1;
            free_depth_next = free_depth + CNT_W'(1);
          end
        end else begin
          result.status = safs_pkg::ST_BADREL;
        end
      end
      safs_pkg::OP_LOOKUP: begin
        if (live) result.target_read = safs_pkg::WORD_W'(tgt_rdata);
        else      result.status      = safs_pkg::ST_MISS;
      end
      safs_pkg::OP_NOP: begin
      end
    endcase
  end

  // Held request and result payload
  always_ff @(posedge clk) begin
    if (take)      item <= q_head;
    if (exec_done) rsp  <= result;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      free_depth <= '0;
      high_water <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (exec_done) begin
        free_depth <= free_depth_next;
        high_water <= high_water_next;
        rsp_valid  <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid  <= 1'b0;
      end
    end
  end

  // Checks
  a_hw_bound: assert property (@(posedge clk) disable iff (rst)
    high_water <= CNT_W'(MAX_SLOTS))
    else $error("high_water beyond table size");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    free_depth <= high_water)
    else $error("free stack deeper than slots handed out");

  a_state_only_exec: assert property (@(posedge clk) disable iff (rst)
    (state != ST_EXEC) |=> ($stable(free_depth) && $stable(high_water)))
    else $error("allocator state moved outside execute");

  a_rd_after_take: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD) |-> $past(take))
    else $error("table read without a taken request");

endmodule

// File: bench/slot_allocator_free_stack_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_allocator_free_stack_core_test : self-checking bench for the slot allocator
// Drives allocate, release, lookup and unused-mode requests with random gaps
// and result back-pressure, and scores each result against a behavioural copy
// of slot table, free stack and bump pointer, or typed values for directed rows.
// The capacity register sweeps several settings between phases, incl. 0 and 511.
// ----------------------------------------------------------------------------
module slot_allocator_free_stack_core_test;

  localparam int          TABLE_SLOTS = safs_pkg::MAX_SLOTS_DEF;
  localparam logic [63:0] ALL_ONES    = '1;

  // Clock, reset and block inputs (all known from time zero)
  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          req_valid = 1'b0;
  logic                          req_ready;
  safs_pkg::req_item_t           req       = '0;
  logic                          rsp_valid;
  logic                          rsp_ready = 1'b0;
  safs_pkg::rsp_item_t           rsp;
  logic                          psel      = 1'b0;
  logic                          penable   = 1'b0;
  logic                          pwrite    = 1'b0;
  logic [safs_pkg::PADDR_W-1:0]  paddr     = '0;
  logic [31:0]                   pwdata    = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  // Hand-typed expectation travelling alongside the current request
  bit                            req_has_fixed = 1'b0;
  safs_pkg::rsp_item_t           req_fixed     = '0;

  // Behavioural copy of the allocator state
  logic [63:0]                   stored_word [TABLE_SLOTS];
  bit                            ready_mark  [TABLE_SLOTS];
  logic [safs_pkg::SLOT_W-1:0]   free_slots  [TABLE_SLOTS];
  int unsigned                   free_count = 0;
  int unsigned                   bump_next  = 0;
  int unsigned                   cap_reg    = safs_pkg::CAP_RESET;

  safs_pkg::rsp_item_t           pending_results [$];
  int                            mismatches = 0;
  bit                            send_quiet = 1'b0;
  bit                            recv_quiet = 1'b0;

  slot_allocator_free_stack_core uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  // Directed opening: fresh table, capacity at its reset value
  typedef struct packed {
    bit                  fixed_rsp;
    safs_pkg::req_item_t item;
    safs_pkg::rsp_item_t want;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 23;
  directed_row_t directed [DIRECTED_ROWS] = '{
    '{1'b1, '{safs_pkg::MODE_LOOKUP,  8'd0,   64'd0},    '{safs_pkg::ST_MISS,   8'd0, 64'd0}},
    '{1'b1, '{safs_pkg::MODE_RELEASE, 8'd0,   64'd0},    '{safs_pkg::ST_BADREL, 8'd0, 64'd0}},
    '{1'b1, '{safs_pkg::MODE_RELEASE, 8'd255, ALL_ONES}, '{safs_pkg::ST_BADREL, 8'd0, 64'd0}},
    '{1'b1, '{safs_pkg::MODE_LOOKUP,  8'd255, ALL_ONES}, '{safs_pkg::ST_MISS,   8'd0, 64'd0}},
    '{1'b1, '{safs_pkg::MODE_ALLOC,   8'd255, ALL_ONES}, '{safs_pkg::ST_OK,     8'd0, 64'd0}},
    '{1'b1, '{safs_pkg::MODE_ALLOC,   8'd0,   64'd0},    '{safs_pkg::ST_OK,     8'd1, 64'd0}},
    '{1'b1, '{safs_pkg::MODE_LOOKUP,  8'd0,   64'd0},    '{safs_pkg::ST_OK,     8'd0, ALL_ONES}},
    '{1'b1, '{safs_pkg::MODE_LOOKUP,  8'd1,   ALL_ONES}, '{safs_pkg::ST_OK,     8'd0, 64'd0}},
    '{1'b1, '{safs_pkg::MODE_LOOKUP,  8'd2,   64'd0},    '{safs_pkg::ST_MISS,   8'd0, 64'd0}},
    '{1'b1, '{safs_pkg::MODE_RELEASE, 8'd2,   64'd0},    '{safs_pkg::ST_BADREL, 8'd0, 64'd0}},
    '{1'b1, '{safs_pkg::MODE_UNUSED,  8'd255, ALL_ONES}, '{safs_pkg::ST_OK,     8'd0, 64'd0}},
    '{1'b1, '{safs_pkg::MODE_RELEASE, 8'd0,   64'd0},    '{safs_pkg::ST_OK,     8'd0, 64'd0}},
    '{1'b1, '{safs_pkg::MODE_RELEASE, 8'd0,   64'd0},    '{safs_pkg::ST_BADREL, 8'd0, 64'd0}},
    '{1'b1, '{safs_pkg::MODE_LOOKUP,  8'd0,   64'd0},    '{safs_pkg::ST_MISS,   8'd0, 64'd0}},
    '{1'b0, '{safs_pkg::MODE_ALLOC,   8'd7,   64'h0123_4567_89ab_cdef}, '0},
    '{1'b1, '{safs_pkg::MODE_RELEASE, 8'd1,   64'd0},    '{safs_pkg::ST_OK,     8'd0, 64'd0}},
    '{1'b1, '{safs_pkg::MODE_RELEASE, 8'd0,   64'd0},    '{safs_pkg::ST_OK,     8'd0, 64'd0}},
    '{1'b0, '{safs_pkg::MODE_ALLOC,   8'd0,   64'ha5a5_a5a5_a5a5_a5a5}, '0},
    '{1'b0, '{safs_pkg::MODE_ALLOC,   8'd0,   64'h5a5a_5a5a_5a5a_5a5a}, '0},
    '{1'b0, '{safs_pkg::MODE_ALLOC,   8'd0,   64'hfedc_ba98_7654_3210}, '0},
    '{1'b0, '{safs_pkg::MODE_LOOKUP,  8'd0,   64'd0},    '0},
    '{1'b0, '{safs_pkg::MODE_LOOKUP,  8'd2,   64'd0},    '0},
    '{1'b1, '{safs_pkg::MODE_UNUSED,  8'd0,   64'd0},    '{safs_pkg::ST_OK,     8'd0, 64'd0}}
  };

  // A slot is live when it lies below the bump pointer and is marked ready
  function automatic bit slot_is_live(logic [safs_pkg::SLOT_W-1:0] idx);
    return (idx < bump_next) && ready_mark[idx];
  endfunction

  // Expected result of one request; updates the state copy
  function automatic safs_pkg::rsp_item_t allocator_response(safs_pkg::req_item_t r);
    safs_pkg::rsp_item_t res;
    int unsigned         eff_cap;
    res     = '0;
    eff_cap = (cap_reg < TABLE_SLOTS) ? cap_reg : TABLE_SLOTS;
    case (r.mode)
      safs_pkg::MODE_ALLOC: begin
        if (free_count > 0) begin
          free_count--;
          res.slot_given = free_slots[free_count];
        end else if (bump_next < eff_cap) begin
          res.slot_given = safs_pkg::SLOT_W'(bump_next);
          bump_next++;
        end else begin
          res.status = safs_pkg::ST_FULL;
        end
        if (res.status == safs_pkg::ST_OK) begin
          stored_word[res.slot_given] = r.target_word;
          ready_mark[res.slot_given]  = 1'b1;
        end
      end
      safs_pkg::MODE_RELEASE: begin
        if (slot_is_live(r.slot_index)) begin
          ready_mark[r.slot_index] = 1'b0;
          if (free_count < TABLE_SLOTS) begin
            free_slots[free_count] = r.slot_index;
            free_count++;
          end
        end else begin
          res.status = safs_pkg::ST_BADREL;
        end
      end
      safs_pkg::MODE_LOOKUP: begin
        if (slot_is_live(r.slot_index))
          res.target_read = stored_word[r.slot_index];
        else
          res.status = safs_pkg::ST_MISS;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input safs_pkg::rsp_item_t want,
                                 input safs_pkg::rsp_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: expected status=%0d slot=%0d word=%h, got status=%0d slot=%0d word=%h",
               what, want.status, want.slot_given, want.target_read,
               got.status, got.slot_given, got.target_read);
  endtask

  // Scoreboard: results first (they belong to older requests), then intake
  always @(posedge clk) begin
    safs_pkg::rsp_item_t want;
    string               bad;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request pending", '0, rsp);
        end else begin
          want = pending_results.pop_front();
          bad  = "";
          if (rsp.status !== want.status)           bad = {bad, " status"};
          if (rsp.slot_given !== want.slot_given)   bad = {bad, " slot_given"};
          if (rsp.target_read !== want.target_read) bad = {bad, " target_read"};
          if (bad != "")
            report_mismatch({"in", bad}, want, rsp);
        end
      end
      if (req_valid && req_ready) begin
        want = allocator_response(req);
        pending_results.insert(pending_results.size(), req_has_fixed ? req_fixed : want);
      end
    end
  end

  // Result side: random stalls per transaction, with quiet stretches
  initial begin
    int stall;
    wait (!rst);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0)
        recv_quiet = !recv_quiet;
      stall = recv_quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        rsp_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready = 1'b1;
      do @(posedge clk); while (!rsp_valid);
      @(negedge clk);
    end
  end

  // One request transaction; entered and left at a falling edge
  task automatic send_request(input safs_pkg::req_item_t item, input bit fixed,
                              input safs_pkg::rsp_item_t fixed_want);
    int gap;
    if ($urandom_range(0, 39) == 0)
      send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req           = item;
    req_has_fixed = fixed;
    req_fixed     = fixed_want;
    req_valid     = 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_for_drain();
    req_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Capacity write (setup + access), then read it back
  task automatic write_capacity(input logic [safs_pkg::CAP_W-1:0] value);
    logic [31:0] got;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = safs_pkg::REG_SLOT_CAPACITY;
    pwdata  = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    cap_reg = value;
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== 32'(value)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH capacity readback: expected %0d, got %0d", value, got);
    end
  endtask

  // Mostly pick a live slot so releases and lookups get past the checks
  function automatic logic [safs_pkg::SLOT_W-1:0] pick_slot();
    logic [safs_pkg::SLOT_W-1:0] idx;
    idx = safs_pkg::SLOT_W'($urandom_range(0, TABLE_SLOTS - 1));
    if ($urandom_range(0, 3) != 0 && bump_next > 0) begin
      for (int tries = 0; tries < 8; tries++) begin
        idx = safs_pkg::SLOT_W'($urandom_range(0, bump_next - 1));
        if (slot_is_live(idx))
          break;
      end
    end
    return idx;
  endfunction

  // Random traffic with a given mix of modes (remainder is the unused mode)
  task automatic run_traffic(input int count, input int alloc_pct,
                             input int release_pct, input int lookup_pct);
    safs_pkg::req_item_t item;
    int                  roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct)
        item.mode = safs_pkg::MODE_ALLOC;
      else if (roll < alloc_pct + release_pct)
        item.mode = safs_pkg::MODE_RELEASE;
      else if (roll < alloc_pct + release_pct + lookup_pct)
        item.mode = safs_pkg::MODE_LOOKUP;
      else
        item.mode = safs_pkg::MODE_UNUSED;
      item.slot_index = pick_slot();
      case ($urandom_range(0, 7))
        0:       item.target_word = '0;
        1:       item.target_word = ALL_ONES;
        default: item.target_word = {$urandom, $urandom};
      endcase
      send_request(item, 1'b0, '0);
    end
  endtask

  // Main sequence
  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (directed[i])
      send_request(directed[i].item, directed[i].fixed_rsp, directed[i].want);
    wait_for_drain();

    // Capacity below the bump pointer: only recycled slots can be handed out
    write_capacity(9'd0);
    run_traffic(100, 40, 30, 25);
    wait_for_drain();
    write_capacity(9'd1);
    run_traffic(100, 40, 30, 25);
    wait_for_drain();

    // Small capacities: bump pointer grows then the table fills
    write_capacity(9'd8);
    run_traffic(150, 50, 25, 20);
    wait_for_drain();
    write_capacity(9'd16);
    run_traffic(150, 50, 25, 20);
    wait_for_drain();

    // Above the table size: clamps, allocation-heavy to exhaust every slot
    write_capacity(9'd511);
    run_traffic(420, 80, 10, 8);
    wait_for_drain();

    write_capacity(9'd255);
    run_traffic(100, 40, 30, 25);
    wait_for_drain();
    write_capacity(9'd256);
    run_traffic(150, 45, 30, 20);
    wait_for_drain();

    repeat (20) @(negedge clk);
    if (pending_results.size() != 0)
      mismatches += pending_results.size();
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: slot_allocator_free_stack_core.f
hdl/safs_pkg.sv
hdl/safs_ram.sv
hdl/safs_front.sv
hdl/safs_back.sv
hdl/slot_allocator_free_stack_core.sv
bench/slot_allocator_free_stack_core_test.sv
